// ----- hw/rtl/http2_frame_header_validator_top_macros.svh -----
// Assertion macros shared by the frame header validator RTL.
// Each macro samples on the rising edge of clock and is disabled while reset is high.
`ifndef HTTP2_FRAME_HEADER_VALIDATOR_TOP_MACROS_SVH
`define HTTP2_FRAME_HEADER_VALIDATOR_TOP_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication check.
`define H2FHV_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
// Next-cycle implication check.
`define H2FHV_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`else
`define H2FHV_ASSERT_IMPL(label, ante, cons, msg)
`define H2FHV_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

// ----- hw/rtl/h2fhv_pkg.sv -----
// ----------------------------------------------------------------------------
// HTTP/2 frame header validator package
// Verdict codes, frame type codes, flag bit positions, register map and a
// helper for the length divisibility check.
// ----------------------------------------------------------------------------
`default_nettype none

package h2fhv_pkg;

   // Verdict of one frame header.
   typedef enum logic [1:0] {
      VERDICT_OK    = 2'd0,
      VERDICT_PROTO = 2'd1,
      VERDICT_SIZE  = 2'd2
   } verdict_type;

   // Frame type codes.
   localparam logic [7:0] FT_DATA          = 8'd0;
   localparam logic [7:0] FT_HEADERS       = 8'd1;
   localparam logic [7:0] FT_PRIORITY      = 8'd2;
   localparam logic [7:0] FT_RST_STREAM    = 8'd3;
   localparam logic [7:0] FT_SETTINGS      = 8'd4;
   localparam logic [7:0] FT_PUSH_PROMISE  = 8'd5;
   localparam logic [7:0] FT_PING          = 8'd6;
   localparam logic [7:0] FT_GOAWAY        = 8'd7;
   localparam logic [7:0] FT_WINDOW_UPDATE = 8'd8;
   localparam logic [7:0] FT_CONTINUATION  = 8'd9;

   // Flag bit positions.
   localparam int FLAG_ACK_BIT      = 0;
   localparam int FLAG_PADDED_BIT   = 3;
   localparam int FLAG_PRIORITY_BIT = 5;

   // Field widths.
   localparam int LEN_W  = 24;
   localparam int TYPE_W = 8;
   localparam int FLAG_W = 8;
   localparam int SID_W  = 31;
   localparam int DSUM_W = 6;

   // Register map.
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_ADDR_W-1:0] CSR_MAX_FRAME_SIZE = 3'd0;
   localparam logic [LEN_W-1:0] MAX_FRAME_SIZE_RESET = 24'd16384;

   // True when a value up to 63 is a multiple of three. Base-4 digits are
   // summed twice, since 4 is 1 modulo 3; the final sum is at most 4.
   function automatic logic is_mult3(input logic [DSUM_W-1:0] value);
      logic [3:0] sum_a;
      logic [2:0] sum_b;
      begin
         sum_a = {2'b00, value[5:4]} + {2'b00, value[3:2]} + {2'b00, value[1:0]};
         sum_b = {1'b0, sum_a[3:2]} + {1'b0, sum_a[1:0]};
         is_mult3 = (sum_b == 3'd0) || (sum_b == 3'd3);
      end
   endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/h2fhv_pipe.sv -----
// ----------------------------------------------------------------------------
// HTTP/2 frame header check pipeline
// Three register stages: header compares, per-type rules, final verdict.
// ----------------------------------------------------------------------------
`default_nettype none

`include "http2_frame_header_validator_top_macros.svh"

module h2fhv_pipe
   import h2fhv_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic [LEN_W-1:0]  max_frame_size,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic [LEN_W-1:0]  req_frame_length,
   input  wire logic [TYPE_W-1:0] req_hdr_kind,
   input  wire logic [FLAG_W-1:0] req_frame_flags,
   input  wire logic [SID_W-1:0]  req_sid,
   input  wire logic              req_expect_continuation,
   input  wire logic [SID_W-1:0]  req_cont_sid,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic [1:0]             rsp_verdict
);

   // Stage valid bits and ready chain.
   logic s1_valid_ff, s1_valid_in;
   logic s2_valid_ff, s2_valid_in;
   logic s3_valid_ff, s3_valid_in;
   logic s1_ready, s2_ready, s3_ready;

   // Stage 1 payload.
   logic [TYPE_W-1:0] s1_type_ff, s1_type_in;
   logic              s1_ack_ff, s1_pad_ff, s1_prio_ff;
   logic              s1_cont_ff, s1_over_ff, s1_sid_zero_ff, s1_sid_match_ff;
   logic              s1_hi_zero_ff, s1_hi_zero_in;
   logic [3:0]        s1_lo_ff;
   logic [DSUM_W-1:0] s1_dsum_ff, s1_dsum_in;

   // Stage 2 payload.
   logic [TYPE_W-1:0] s2_type_ff;
   logic              s2_cont_ff, s2_over_ff, s2_sid_match_ff;
   verdict_type       s2_v_data_ff, s2_v_headers_ff, s2_v_priority_ff, s2_v_rst_ff;
   verdict_type       s2_v_settings_ff, s2_v_push_ff, s2_v_ping_ff, s2_v_goaway_ff;
   verdict_type       s2_v_window_ff;
   verdict_type       v_data_in, v_headers_in, v_priority_in, v_rst_in;
   verdict_type       v_settings_in, v_push_in, v_ping_in, v_goaway_in, v_window_in;

   // Stage 3 payload.
   verdict_type       s3_verdict_ff, s3_verdict_in;

   // A stage takes new data when it is empty or its content moves on.
   assign s3_ready  = !s3_valid_ff || !rsp_stall;
   assign s2_ready  = !s2_valid_ff || s3_ready;
   assign s1_ready  = !s1_valid_ff || s2_ready;
   assign req_stall = !s1_ready;

   assign s1_valid_in = s1_ready ? req_valid   : s1_valid_ff;
   assign s2_valid_in = s2_ready ? s1_valid_ff : s2_valid_ff;
   assign s3_valid_in = s3_ready ? s2_valid_ff : s3_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         s3_valid_ff <= s3_valid_in;
      end
   end

   // Stage 1: wide compares and the base-4 digit sum of the length.
   always_comb begin
      logic [2:0] pair_sum [6];
      logic [3:0] quad_a, quad_b, quad_c;
      for (int i = 0; i < 6; i++) begin
         pair_sum[i] = {1'b0, req_frame_length[4*i+3 -: 2]} +
                       {1'b0, req_frame_length[4*i+1 -: 2]};
      end
      quad_a = {1'b0, pair_sum[0]} + {1'b0, pair_sum[1]};
      quad_b = {1'b0, pair_sum[2]} + {1'b0, pair_sum[3]};
      quad_c = {1'b0, pair_sum[4]} + {1'b0, pair_sum[5]};
      s1_dsum_in = {2'b00, quad_a} + {2'b00, quad_b} + {2'b00, quad_c};
   end

   assign s1_type_in    = req_hdr_kind;
   assign s1_hi_zero_in = (req_frame_length[LEN_W-1:4] == '0);

   always_ff @(posedge clock) begin
      if (s1_ready) begin
         s1_type_ff      <= s1_type_in;
         s1_ack_ff       <= req_frame_flags[FLAG_ACK_BIT];
         s1_pad_ff       <= req_frame_flags[FLAG_PADDED_BIT];
         s1_prio_ff      <= req_frame_flags[FLAG_PRIORITY_BIT];
         s1_cont_ff      <= req_expect_continuation;
         s1_over_ff      <= (req_frame_length > max_frame_size);
         s1_sid_zero_ff  <= (req_sid == '0);
         s1_sid_match_ff <= (req_sid == req_cont_sid);
         s1_hi_zero_ff   <= s1_hi_zero_in;
         s1_lo_ff        <= req_frame_length[3:0];
         s1_dsum_ff      <= s1_dsum_in;
      end
   end

   // Stage 2: length classes and the verdict each frame type would give.
   always_comb begin
      logic       len0, len4, len5, len8, lt8, lt_need, mult6;
      logic [2:0] need;
      len0    = s1_hi_zero_ff && (s1_lo_ff == 4'd0);
      len4    = s1_hi_zero_ff && (s1_lo_ff == 4'd4);
      len5    = s1_hi_zero_ff && (s1_lo_ff == 4'd5);
      len8    = s1_hi_zero_ff && (s1_lo_ff == 4'd8);
      lt8     = s1_hi_zero_ff && !s1_lo_ff[3];
      need    = (s1_prio_ff ? 3'd5 : 3'd0) + {2'b00, s1_pad_ff};
      lt_need = s1_hi_zero_ff && (s1_lo_ff < {1'b0, need});
      mult6   = !s1_lo_ff[0] && is_mult3(s1_dsum_ff);

      v_data_in     = s1_sid_zero_ff ? VERDICT_PROTO :
                      (s1_pad_ff && len0) ? VERDICT_SIZE : VERDICT_OK;
      v_headers_in  = s1_sid_zero_ff ? VERDICT_PROTO :
                      lt_need ? VERDICT_SIZE : VERDICT_OK;
      v_priority_in = s1_sid_zero_ff ? VERDICT_PROTO :
                      !len5 ? VERDICT_SIZE : VERDICT_OK;
      v_rst_in      = s1_sid_zero_ff ? VERDICT_PROTO :
                      !len4 ? VERDICT_SIZE : VERDICT_OK;
      if (!s1_sid_zero_ff) begin
         v_settings_in = VERDICT_PROTO;
      end else if (s1_ack_ff) begin
         v_settings_in = len0 ? VERDICT_OK : VERDICT_SIZE;
      end else begin
         v_settings_in = (len0 || !mult6) ? VERDICT_SIZE : VERDICT_OK;
      end
      v_push_in     = s1_sid_zero_ff ? VERDICT_PROTO : VERDICT_OK;
      v_ping_in     = !s1_sid_zero_ff ? VERDICT_PROTO :
                      !len8 ? VERDICT_SIZE :
                      s1_ack_ff ? VERDICT_PROTO : VERDICT_OK;
      v_goaway_in   = !s1_sid_zero_ff ? VERDICT_PROTO :
                      lt8 ? VERDICT_SIZE : VERDICT_OK;
      v_window_in   = !len4 ? VERDICT_SIZE : VERDICT_OK;
   end

   always_ff @(posedge clock) begin
      if (s2_ready) begin
         s2_type_ff       <= s1_type_ff;
         s2_cont_ff       <= s1_cont_ff;
         s2_over_ff       <= s1_over_ff;
         s2_sid_match_ff  <= s1_sid_match_ff;
         s2_v_data_ff     <= v_data_in;
         s2_v_headers_ff  <= v_headers_in;
         s2_v_priority_ff <= v_priority_in;
         s2_v_rst_ff      <= v_rst_in;
         s2_v_settings_ff <= v_settings_in;
         s2_v_push_ff     <= v_push_in;
         s2_v_ping_ff     <= v_ping_in;
         s2_v_goaway_ff   <= v_goaway_in;
         s2_v_window_ff   <= v_window_in;
      end
   end

   // Stage 3: an expected continuation overrides all, then the size limit,
   // then the rule of the frame type. Stray continuation and unknown types fail.
   always_comb begin
      if (s2_cont_ff) begin
         s3_verdict_in = ((s2_type_ff == FT_CONTINUATION) && s2_sid_match_ff) ?
                         VERDICT_OK : VERDICT_PROTO;
      end else if (s2_over_ff) begin
         s3_verdict_in = VERDICT_SIZE;
      end else begin
         case (s2_type_ff)
            FT_DATA:          s3_verdict_in = s2_v_data_ff;
            FT_HEADERS:       s3_verdict_in = s2_v_headers_ff;
            FT_PRIORITY:      s3_verdict_in = s2_v_priority_ff;
            FT_RST_STREAM:    s3_verdict_in = s2_v_rst_ff;
            FT_SETTINGS:      s3_verdict_in = s2_v_settings_ff;
            FT_PUSH_PROMISE:  s3_verdict_in = s2_v_push_ff;
            FT_PING:          s3_verdict_in = s2_v_ping_ff;
            FT_GOAWAY:        s3_verdict_in = s2_v_goaway_ff;
            FT_WINDOW_UPDATE: s3_verdict_in = s2_v_window_ff;
            default:          s3_verdict_in = VERDICT_PROTO;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (s3_ready) begin
         s3_verdict_ff <= s3_verdict_in;
      end
   end

   assign rsp_valid   = s3_valid_ff;
   assign rsp_verdict = s3_verdict_ff;

   // Checks on the pipeline control.
   `H2FHV_ASSERT_IMPL(a_verdict_legal, rsp_valid, rsp_verdict != 2'd3,
      "verdict code 3 driven")
   `H2FHV_ASSERT_IMPL(a_stall_full, req_stall, s1_valid_ff && s2_valid_ff && s3_valid_ff,
      "input stalled with a free stage")
   `H2FHV_ASSERT_NEXT(a_s2_hold, s2_valid_ff && !s2_ready,
      s2_valid_ff && $stable(s2_type_ff), "stage 2 lost an item while blocked")
   `H2FHV_ASSERT_NEXT(a_s3_fill, s2_valid_ff && s3_ready, s3_valid_ff,
      "stage 2 item did not reach the output")

endmodule

`default_nettype wire

// ----- hw/rtl/http2_frame_header_validator_top.sv -----
// ----------------------------------------------------------------------------
// HTTP/2 frame header validator
// Checks one decoded frame header per transfer and returns a verdict.
// ----------------------------------------------------------------------------
// Usage:
//   The req_ channel carries one decoded frame header per transfer; the rsp_
//   channel returns one verdict per header, in order: 0 ok, 1 protocol error,
//   2 frame size error. A transfer happens at a clock edge where valid is high
//   and stall is low.
//   The csr_ port holds max_frame_size at byte address 0; write it only while
//   no header is in flight.
//   A header's verdict passes through the three register stages of the check
//   pipeline (compares, per-type rules, final select) before it is valid on
//   rsp_. Throughput is one header per cycle while rsp_stall is low.
//   When the receiver stalls, the verdict holds on rsp_ and the stages behind
//   it keep filling; req_stall rises only when all three stages are occupied.
//   A synchronous reset empties the pipeline and sets max_frame_size to 16384.
// ----------------------------------------------------------------------------
`default_nettype none

module http2_frame_header_validator_top
   import h2fhv_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   // Header input channel
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic [LEN_W-1:0]      req_frame_length,
   input  wire logic [TYPE_W-1:0]     req_hdr_kind,
   input  wire logic [FLAG_W-1:0]     req_frame_flags,
   input  wire logic [SID_W-1:0]      req_sid,
   input  wire logic                  req_expect_continuation,
   input  wire logic [SID_W-1:0]      req_cont_sid,
   // Verdict output channel
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic [1:0]                 rsp_verdict,
   // Register port
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0]      csr_prdata,
   output logic                       csr_pready
);

   logic [LEN_W-1:0] max_frame_size_ff;
   logic             csr_write;
   logic             csr_hit;

   // Register write on the access phase of a transfer; decode by word index.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_hit    = (csr_paddr[CSR_ADDR_W-1:2] == CSR_MAX_FRAME_SIZE[CSR_ADDR_W-1:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         max_frame_size_ff <= MAX_FRAME_SIZE_RESET;
      end else if (csr_write && csr_hit) begin
         max_frame_size_ff <= csr_pwdata[LEN_W-1:0];
      end
   end

   // Register read.
   always_comb begin
      if (csr_hit) begin
         csr_prdata = {{(CSR_DATA_W-LEN_W){1'b0}}, max_frame_size_ff};
      end else begin
         csr_prdata = '0;
      end
   end

   // Check pipeline.
   h2fhv_pipe u_pipe (
      .clock                   (clock),
      .reset                   (reset),
      .max_frame_size          (max_frame_size_ff),
      .req_valid               (req_valid),
      .req_stall               (req_stall),
      .req_frame_length        (req_frame_length),
      .req_hdr_kind            (req_hdr_kind),
      .req_frame_flags         (req_frame_flags),
      .req_sid                 (req_sid),
      .req_expect_continuation (req_expect_continuation),
      .req_cont_sid            (req_cont_sid),
      .rsp_valid               (rsp_valid),
      .rsp_stall               (rsp_stall),
      .rsp_verdict             (rsp_verdict)
   );

endmodule

`default_nettype wire

// ----- tb/frame_verdict_checker.sv -----
// ----------------------------------------------------------------------------
// Frame verdict checker
// Watches the header and verdict channels and the register port. It predicts
// the verdict of every accepted header and compares each verdict transfer,
// in order, against the oldest prediction.
// ----------------------------------------------------------------------------
module frame_verdict_checker
   import h2fhv_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_stall,
   input  logic [LEN_W-1:0]      req_frame_length,
   input  logic [TYPE_W-1:0]     req_hdr_kind,
   input  logic [FLAG_W-1:0]     req_frame_flags,
   input  logic [SID_W-1:0]      req_sid,
   input  logic                  req_expect_continuation,
   input  logic [SID_W-1:0]      req_cont_sid,
   input  logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  logic [1:0]            rsp_verdict,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   input  logic [CSR_DATA_W-1:0] csr_prdata,
   input  logic                  csr_pready,
   output int                    mismatch_count,
   output int                    verdicts_pending,
   output int                    ok_count,
   output int                    proto_count,
   output int                    size_count
);

   // Payload sizes fixed by the protocol.
   localparam int HEADERS_PRIORITY_LEN = 5;
   localparam int HEADERS_PAD_LEN      = 1;
   localparam int PRIORITY_LEN         = 5;
   localparam int RST_STREAM_LEN       = 4;
   localparam int SETTINGS_ENTRY_LEN   = 6;
   localparam int PING_LEN             = 8;
   localparam int GOAWAY_MIN_LEN       = 8;
   localparam int WINDOW_UPDATE_LEN    = 4;
   localparam int REPORT_LIMIT         = 10;

   verdict_type      pending_verdicts[$];
   logic [LEN_W-1:0] size_limit = MAX_FRAME_SIZE_RESET;

   initial begin
      mismatch_count   = 0;
      verdicts_pending = 0;
      ok_count         = 0;
      proto_count      = 0;
      size_count       = 0;
   end

   // Verdict of one frame header under the given payload size limit.
   function automatic verdict_type predict_verdict(
      input logic [LEN_W-1:0]  length,
      input logic [TYPE_W-1:0] ftype,
      input logic [FLAG_W-1:0] flags,
      input logic [SID_W-1:0]  sid,
      input logic              cont,
      input logic [SID_W-1:0]  esid,
      input logic [LEN_W-1:0]  limit
   );
      int   need;
      logic no_sid;
      logic ack;
      no_sid = (sid == '0);
      ack    = flags[FLAG_ACK_BIT];
      // An expected CONTINUATION only needs the right type and stream.
      if (cont) begin
         return (ftype == FT_CONTINUATION && sid == esid) ? VERDICT_OK : VERDICT_PROTO;
      end
      if (length > limit) return VERDICT_SIZE;
      case (ftype)
         FT_DATA: begin
            if (no_sid) return VERDICT_PROTO;
            if (flags[FLAG_PADDED_BIT] && length == '0) return VERDICT_SIZE;
            return VERDICT_OK;
         end
         FT_HEADERS: begin
            if (no_sid) return VERDICT_PROTO;
            need = (flags[FLAG_PRIORITY_BIT] ? HEADERS_PRIORITY_LEN : 0)
                 + (flags[FLAG_PADDED_BIT] ? HEADERS_PAD_LEN : 0);
            return (length < need) ? VERDICT_SIZE : VERDICT_OK;
         end
         FT_PRIORITY: begin
            if (no_sid) return VERDICT_PROTO;
            return (length != PRIORITY_LEN) ? VERDICT_SIZE : VERDICT_OK;
         end
         FT_RST_STREAM: begin
            if (no_sid) return VERDICT_PROTO;
            return (length != RST_STREAM_LEN) ? VERDICT_SIZE : VERDICT_OK;
         end
         FT_SETTINGS: begin
            if (!no_sid) return VERDICT_PROTO;
            if (ack) return (length != '0) ? VERDICT_SIZE : VERDICT_OK;
            return (length == '0 || length % SETTINGS_ENTRY_LEN != 0) ?
                   VERDICT_SIZE : VERDICT_OK;
         end
         FT_PUSH_PROMISE: begin
            return no_sid ? VERDICT_PROTO : VERDICT_OK;
         end
         FT_PING: begin
            if (!no_sid) return VERDICT_PROTO;
            if (length != PING_LEN) return VERDICT_SIZE;
            return ack ? VERDICT_PROTO : VERDICT_OK;
         end
         FT_GOAWAY: begin
            if (!no_sid) return VERDICT_PROTO;
            return (length < GOAWAY_MIN_LEN) ? VERDICT_SIZE : VERDICT_OK;
         end
         FT_WINDOW_UPDATE: begin
            return (length != WINDOW_UPDATE_LEN) ? VERDICT_SIZE : VERDICT_OK;
         end
         // Stray CONTINUATION and unknown types.
         default: return VERDICT_PROTO;
      endcase
   endfunction

   // Count a failure; only the first few are printed.
   task automatic note_failure(input string text);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT) $display("checker: %s", text);
   endtask

   // Per-edge bookkeeping: compare verdicts, queue predictions, track the register.
   always @(posedge clock) begin
      verdict_type want;
      logic        reg_hit;
      if (!reset) begin
         reg_hit = (csr_paddr[CSR_ADDR_W-1:2] == CSR_MAX_FRAME_SIZE[CSR_ADDR_W-1:2]);

         // Verdict transfer against the oldest prediction.
         if (rsp_valid && !rsp_stall) begin
            if (pending_verdicts.size() == 0) begin
               note_failure($sformatf("verdict %0d at %0t with no header waiting",
                                      rsp_verdict, $time));
            end else begin
               want = pending_verdicts.pop_front();
               case (want)
                  VERDICT_OK:    ok_count++;
                  VERDICT_PROTO: proto_count++;
                  default:       size_count++;
               endcase
               if (rsp_verdict !== want) begin
                  note_failure($sformatf("verdict mismatch at %0t: expected %0d (%s), got %0d",
                                         $time, want, want.name(), rsp_verdict));
               end
            end
         end

         // Header transfer: predict under the current limit.
         if (req_valid && !req_stall) begin
            pending_verdicts.push_back(predict_verdict(req_frame_length, req_hdr_kind,
                                                       req_frame_flags, req_sid,
                                                       req_expect_continuation,
                                                       req_cont_sid, size_limit));
         end

         // Register read back and register write.
         if (csr_psel && csr_penable && csr_pready && reg_hit) begin
            if (csr_pwrite) begin
               size_limit = csr_pwdata[LEN_W-1:0];
            end else if (csr_prdata[LEN_W-1:0] !== size_limit) begin
               note_failure($sformatf("max_frame_size read at %0t: expected %0d, got %0d",
                                      $time, size_limit, csr_prdata[LEN_W-1:0]));
            end
         end

         verdicts_pending = pending_verdicts.size();
      end
   end

endmodule

// ----- tb/testbench.sv -----
// ----------------------------------------------------------------------------
// Frame header validator testbench
// Drives directed and random frame headers through the validator under several
// max_frame_size settings and idle patterns, including a long verdict
// hold-off that backs up the pipeline. The checker predicts and compares.
// ----------------------------------------------------------------------------
module testbench;
   import h2fhv_pkg::*;

   localparam int CYCLE_LIMIT     = 200000;
   localparam int PHASE_COUNT     = 6;
   localparam int ITEMS_PER_PHASE = 300;
   localparam int BURST_ITEMS     = 30;
   localparam int HOLD_CYCLES     = 60;
   localparam int DRAIN_CYCLES    = 10;
   localparam logic [FLAG_W-1:0] FLAG_ACK      = FLAG_W'(1) << FLAG_ACK_BIT;
   localparam logic [FLAG_W-1:0] FLAG_PADDED   = FLAG_W'(1) << FLAG_PADDED_BIT;
   localparam logic [FLAG_W-1:0] FLAG_PRIORITY = FLAG_W'(1) << FLAG_PRIORITY_BIT;
   localparam logic [SID_W-1:0]  MAX_SID       = '1;
   localparam logic [CSR_ADDR_W-1:0] CSR_UNMAPPED = CSR_MAX_FRAME_SIZE + 3'd4;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [LEN_W-1:0]      req_frame_length = '0;
   logic [TYPE_W-1:0]     req_hdr_kind = '0;
   logic [FLAG_W-1:0]     req_frame_flags = '0;
   logic [SID_W-1:0]      req_sid = '0;
   logic                  req_expect_continuation = 1'b0;
   logic [SID_W-1:0]      req_cont_sid = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [1:0]            rsp_verdict;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   int mismatch_count;
   int verdicts_pending;
   int ok_count;
   int proto_count;
   int size_count;

   int               idle_pct = 0;
   int               stall_pct = 0;
   int               hold_request = 0;
   int               hold_left = 0;
   int               cycle_count = 0;
   int               headers_sent = 0;
   logic [LEN_W-1:0] current_limit = MAX_FRAME_SIZE_RESET;

   http2_frame_header_validator_top u_top (.*);

   frame_verdict_checker u_checker (.*);

   // Clock: period 20.
   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // Watchdog.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Run stopped after %0d cycles with %0d verdicts outstanding.",
                  cycle_count, verdicts_pending);
         $display("testbench: FAIL");
         $finish;
      end
   end

   // Verdict receiver: random stalls, or a long hold-off when one is requested.
   always @(negedge clock) begin
      if (hold_request != 0) begin
         hold_left = HOLD_CYCLES;
         hold_request = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   // One register access; drops psel after the access phase and returns with the port idle.
   task automatic access_register(input logic is_write, input logic [CSR_ADDR_W-1:0] addr,
                                  input logic [CSR_DATA_W-1:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= is_write;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(negedge clock);
   endtask

   // Offer one header after a random gap and wait for its transfer.
   task automatic send_header(input logic [LEN_W-1:0] frame_length,
                              input logic [TYPE_W-1:0] hdr_kind,
                              input logic [FLAG_W-1:0] frame_flags,
                              input logic [SID_W-1:0] sid,
                              input logic expect_cont,
                              input logic [SID_W-1:0] expected_sid);
      int gap;
      gap = 0;
      while ($urandom_range(99) < idle_pct) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid               <= 1'b1;
      req_frame_length        <= frame_length;
      req_hdr_kind            <= hdr_kind;
      req_frame_flags         <= frame_flags;
      req_sid                 <= sid;
      req_expect_continuation <= expect_cont;
      req_cont_sid            <= expected_sid;
      do @(posedge clock); while (req_stall);
      headers_sent++;
      @(negedge clock);
   endtask

   // Random header, weighted toward the boundaries of the per-type rules.
   task automatic send_random_header();
      logic [LEN_W-1:0]  frame_length;
      logic [TYPE_W-1:0] hdr_kind;
      logic [FLAG_W-1:0] frame_flags;
      logic [SID_W-1:0]  sid;
      logic              expect_cont;
      logic [SID_W-1:0]  expected_sid;
      case ($urandom_range(7))
         0, 1:    frame_length = LEN_W'($urandom_range(12));
         2:       frame_length = LEN_W'(6 * $urandom_range(50) + $urandom_range(1));
         3:       frame_length = current_limit + LEN_W'($urandom_range(2)) - 1'b1;
         4:       frame_length = LEN_W'($urandom_range(current_limit));
         5:       frame_length = LEN_W'($urandom);
         default: frame_length = LEN_W'($urandom_range(300));
      endcase
      hdr_kind = ($urandom_range(99) < 90) ? TYPE_W'($urandom_range(9))
                                           : TYPE_W'($urandom_range(255, 10));
      frame_flags = FLAG_W'($urandom);
      if ($urandom_range(1) == 0) frame_flags &= (FLAG_ACK | FLAG_PADDED | FLAG_PRIORITY);
      case ($urandom_range(9))
         0, 1, 2: sid = '0;
         3:       sid = MAX_SID;
         default: sid = SID_W'($urandom);
      endcase
      // A fifth of the headers arrive while a CONTINUATION is expected.
      expect_cont = ($urandom_range(99) < 20);
      expected_sid = SID_W'($urandom);
      if (expect_cont) begin
         if ($urandom_range(4) != 0) expected_sid = sid;
         if ($urandom_range(4) != 0) hdr_kind = FT_CONTINUATION;
      end
      send_header(frame_length, hdr_kind, frame_flags, sid, expect_cont, expected_sid);
   endtask

   // Stop offering headers and let every verdict come back.
   task automatic drain_verdicts();
      req_valid <= 1'b0;
      while (verdicts_pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // Main stimulus.
   initial begin
      logic [CSR_DATA_W-1:0] setting;
      int                    phase;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reset value of the limit, then directed headers under it.
      access_register(1'b0, CSR_MAX_FRAME_SIZE, '0);
      send_header(0, FT_DATA, 0, 1, 1'b0, 0);
      send_header(0, FT_DATA, 0, 0, 1'b0, 0);
      send_header(0, FT_DATA, FLAG_PADDED, 5, 1'b0, 0);
      send_header(MAX_FRAME_SIZE_RESET + 1, FT_DATA, 0, 3, 1'b0, 0);
      send_header(MAX_FRAME_SIZE_RESET, FT_DATA, '1, MAX_SID, 1'b0, MAX_SID);
      send_header(5, FT_HEADERS, FLAG_PRIORITY | FLAG_PADDED, 1, 1'b0, 0);
      send_header(6, FT_HEADERS, FLAG_PRIORITY | FLAG_PADDED, 1, 1'b0, 0);
      send_header(0, FT_HEADERS, 0, 0, 1'b0, 0);
      send_header(5, FT_PRIORITY, 0, 9, 1'b0, 0);
      send_header(4, FT_PRIORITY, 0, 9, 1'b0, 0);
      send_header(4, FT_RST_STREAM, 0, 2, 1'b0, 0);
      send_header(4, FT_RST_STREAM, 0, 0, 1'b0, 0);
      send_header(0, FT_SETTINGS, FLAG_ACK, 0, 1'b0, 0);
      send_header(6, FT_SETTINGS, FLAG_ACK, 0, 1'b0, 0);
      send_header(0, FT_SETTINGS, 0, 0, 1'b0, 0);
      send_header(12, FT_SETTINGS, 0, 0, 1'b0, 0);
      send_header(7, FT_SETTINGS, 0, 0, 1'b0, 0);
      send_header(6, FT_SETTINGS, 0, 1, 1'b0, 0);
      send_header(0, FT_PUSH_PROMISE, 0, 0, 1'b0, 0);
      send_header(8, FT_PING, FLAG_ACK, 0, 1'b0, 0);
      send_header(7, FT_PING, 0, 0, 1'b0, 0);
      send_header(7, FT_GOAWAY, 0, 1, 1'b0, 0);
      send_header(4, FT_WINDOW_UPDATE, 0, 0, 1'b0, 0);
      send_header(0, FT_CONTINUATION, 0, 1, 1'b0, 0);
      send_header(0, '1, 0, 1, 1'b0, 0);
      send_header('1, FT_CONTINUATION, 0, 77, 1'b1, 77);
      send_header(0, FT_CONTINUATION, 0, 77, 1'b1, 78);
      send_header(4, FT_WINDOW_UPDATE, 0, 77, 1'b1, 77);
      drain_verdicts();

      // Random phases, each under its own limit and idle pattern.
      for (phase = 0; phase < PHASE_COUNT; phase++) begin
         setting = $urandom;
         case (phase)
            0:       setting[LEN_W-1:0] = '1;
            1:       setting[LEN_W-1:0] = '0;
            2:       setting[LEN_W-1:0] = 8;
            3:       setting[LEN_W-1:0] = LEN_W'($urandom_range(24'hFFFFFF,
                                                                MAX_FRAME_SIZE_RESET));
            4:       setting[LEN_W-1:0] = MAX_FRAME_SIZE_RESET;
            default: ;
         endcase
         access_register(1'b1, CSR_MAX_FRAME_SIZE, setting);
         access_register(1'b1, CSR_UNMAPPED, $urandom);
         access_register(1'b0, CSR_MAX_FRAME_SIZE, '0);
         current_limit = setting[LEN_W-1:0];

         case (phase % 4)
            0:       begin idle_pct = 0;  stall_pct = 0;  end
            1:       begin idle_pct = 81; stall_pct = 0;  end
            2:       begin idle_pct = 0;  stall_pct = 81; end
            default: begin idle_pct = 6;  stall_pct = 6;  end
         endcase

         // Back-to-back headers against a long verdict hold-off.
         if (phase == 0) begin
            hold_request = 1;
            repeat (BURST_ITEMS) send_random_header();
         end
         repeat (ITEMS_PER_PHASE) send_random_header();
         drain_verdicts();
      end

      $display("Covered %0d headers under %0d limit settings (reset, zero, eight, maximum, random).",
               headers_sent, PHASE_COUNT + 1);
      $display("Verdicts: %0d ok, %0d protocol error, %0d frame size error; %0d outstanding.",
               ok_count, proto_count, size_count, verdicts_pending);
      if (mismatch_count == 0 && verdicts_pending == 0) begin
         $display("testbench: PASS");
      end else begin
         $display("testbench: FAIL");
      end
      $finish;
   end

endmodule
